@@ rtl/core/l2c_pkg.sv @@
// Shared types and constants for the L2 header classifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package l2c_pkg;

  // EtherType values and header geometry.
  localparam logic [15:0] VLAN_TPID    = 16'h8100;
  localparam logic [15:0] IPV4_TYPE    = 16'h0800;
  localparam logic [7:0]  IPV4_HDR_LEN = 8'd20;
  localparam logic [7:0]  ETYPE_LEN    = 8'd2;
  localparam logic [5:0]  NONCE_MAX    = 6'd32;
  localparam logic [7:0]  LEN_MAX      = 8'd255;

  // Inner EtherType offsets and the minimum lengths that make them readable.
  localparam logic [7:0] OFF_UNTAGGED = 8'd12;
  localparam logic [7:0] OFF_VLAN     = 8'd16;
  localparam logic [7:0] MIN_UNTAGGED = 8'd14;
  localparam logic [7:0] MIN_VLAN     = 8'd18;

  // Byte positions that are captured.
  localparam logic [7:0] POS_OUTER_HI  = 8'd12;
  localparam logic [7:0] POS_OUTER_LO  = 8'd13;
  localparam logic [7:0] POS_UNTAG_PB  = 8'd14;
  localparam logic [7:0] POS_UNTAG_WB  = 8'd15;
  localparam logic [7:0] POS_TAGGED_HI = 8'd16;
  localparam logic [7:0] POS_TAGGED_LO = 8'd17;
  localparam logic [7:0] POS_VLAN_PB   = 8'd18;
  localparam logic [7:0] POS_VLAN_WB   = 8'd19;

  // Reset values of the configuration registers.
  localparam logic [15:0] MARKER_RESET = 16'h0000;
  localparam logic [5:0]  NONCE_RESET  = 6'd12;

  typedef enum logic {
    REG_MARKER = 1'b0,
    REG_NONCE  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_UNTAGGED = 2'd1,
    KIND_VLAN     = 2'd2
  } header_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    header_kind_t header_kind;
    logic [4:0]   l2_prefix_len;
    logic         ipv4_ok;
    logic [4:0]   ipv4_offset;
    logic         has_marker;
    logic         policy_valid;
    logic [7:0]   policy_id;
    logic         worker_valid;
    logic [7:0]   worker_index;
    logic         frag_valid;
    logic [5:0]   frag_magic_offset;
  } result_t;

  typedef struct packed {
    logic [15:0] marker_ethertype;
    logic [5:0]  nonce_bytes;
  } cfg_t;

  // Everything the classifier needs about one finished frame.
  typedef struct packed {
    logic [7:0]  frame_len;
    logic [15:0] outer_type_word;
    logic [15:0] tagged_type_word;
    logic [7:0]  untag_policy;
    logic [7:0]  untag_worker;
    logic [7:0]  vlan_policy;
    logic [7:0]  vlan_worker;
  } frame_t;

endpackage

`default_nettype wire

@@ rtl/core/l2c_capture.sv @@
// Byte counter, header capture registers and the frame summary register.
// Depends on l2c_pkg.
`default_nettype none

module l2c_capture (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire l2c_pkg::item_t item,
  output logic                frame_valid,
  input  wire logic           frame_ready,
  output l2c_pkg::frame_t     frame
);

  logic [7:0]  byte_count;
  logic [7:0]  byte_count_next;
  logic [7:0]  frame_len_next;
  logic [15:0] outer_type_word;
  logic [15:0] outer_type_word_next;
  logic [15:0] tagged_type_word;
  logic [15:0] tagged_type_word_next;
  logic [7:0]  after_type_bytes [4];
  logic [7:0]  after_type_bytes_next [4];
  logic        accept;
  logic        frame_done;

  assign item_ready = !frame_valid || frame_ready;
  assign accept     = item_valid && item_ready;
  assign frame_done = accept && item.last_byte;

  assign frame_len_next = (byte_count == l2c_pkg::LEN_MAX) ? l2c_pkg::LEN_MAX
                                                            : byte_count + 8'd1;

  always_comb begin
    byte_count_next = byte_count;
    if (accept) begin
      byte_count_next = item.last_byte ? 8'd0 : frame_len_next;
    end
  end

  // Merge the current byte into the captured header fields.
  always_comb begin
    outer_type_word_next  = outer_type_word;
    tagged_type_word_next = tagged_type_word;
    for (int i = 0; i < 4; i++) begin
      after_type_bytes_next[i] = after_type_bytes[i];
    end
    case (byte_count)
      l2c_pkg::POS_OUTER_HI:  outer_type_word_next[15:8]  = item.data_byte;
      l2c_pkg::POS_OUTER_LO:  outer_type_word_next[7:0]   = item.data_byte;
      l2c_pkg::POS_UNTAG_PB:  after_type_bytes_next[0]    = item.data_byte;
      l2c_pkg::POS_UNTAG_WB:  after_type_bytes_next[1]    = item.data_byte;
      l2c_pkg::POS_TAGGED_HI: tagged_type_word_next[15:8] = item.data_byte;
      l2c_pkg::POS_TAGGED_LO: tagged_type_word_next[7:0]  = item.data_byte;
      l2c_pkg::POS_VLAN_PB:   after_type_bytes_next[2]    = item.data_byte;
      l2c_pkg::POS_VLAN_WB:   after_type_bytes_next[3]    = item.data_byte;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 8'd0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      outer_type_word  <= outer_type_word_next;
      tagged_type_word <= tagged_type_word_next;
      for (int i = 0; i < 4; i++) begin
        after_type_bytes[i] <= after_type_bytes_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_done) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      frame.frame_len        <= frame_len_next;
      frame.outer_type_word  <= outer_type_word_next;
      frame.tagged_type_word <= tagged_type_word_next;
      frame.untag_policy     <= after_type_bytes_next[0];
      frame.untag_worker     <= after_type_bytes_next[1];
      frame.vlan_policy      <= after_type_bytes_next[2];
      frame.vlan_worker      <= after_type_bytes_next[3];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/l2c_classify.sv @@
// Classification of one frame summary and the result register.
// Depends on l2c_pkg.
`default_nettype none

module l2c_classify (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire l2c_pkg::cfg_t   cfg,
  input  wire logic            frame_valid,
  output logic                 frame_ready,
  input  wire l2c_pkg::frame_t frame,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output l2c_pkg::result_t     result
);

  logic                  marker_on;
  logic                  outer_ok;
  logic                  vlan_ok;
  logic [7:0]            off;
  logic [15:0]           inner_type;
  logic [7:0]            pb;
  logic [7:0]            wb;
  logic [7:0]            frag_end;
  logic                  is_marker;
  logic                  policy_ok;
  logic                  ipv4_hit;
  logic                  frag_hit;
  l2c_pkg::header_kind_t kind;
  l2c_pkg::result_t      result_next;

  assign marker_on = cfg.marker_ethertype != 16'h0000;

  assign outer_ok = frame.frame_len >= l2c_pkg::MIN_UNTAGGED &&
                    (frame.outer_type_word == l2c_pkg::IPV4_TYPE ||
                     (marker_on && frame.outer_type_word == cfg.marker_ethertype));
  assign vlan_ok  = frame.frame_len >= l2c_pkg::MIN_VLAN &&
                    frame.outer_type_word == l2c_pkg::VLAN_TPID &&
                    (frame.tagged_type_word == l2c_pkg::IPV4_TYPE ||
                     (marker_on && frame.tagged_type_word == cfg.marker_ethertype));

  always_comb begin
    if (outer_ok) begin
      kind       = l2c_pkg::KIND_UNTAGGED;
      off        = l2c_pkg::OFF_UNTAGGED;
      inner_type = frame.outer_type_word;
      pb         = frame.untag_policy;
      wb         = frame.untag_worker;
    end else if (vlan_ok) begin
      kind       = l2c_pkg::KIND_VLAN;
      off        = l2c_pkg::OFF_VLAN;
      inner_type = frame.tagged_type_word;
      pb         = frame.vlan_policy;
      wb         = frame.vlan_worker;
    end else begin
      kind       = l2c_pkg::KIND_NONE;
      off        = 8'd0;
      inner_type = 16'h0000;
      pb         = 8'd0;
      wb         = 8'd0;
    end
  end

  assign frag_end  = off + 8'd4 + {2'b00, cfg.nonce_bytes};
  assign is_marker = marker_on && inner_type == cfg.marker_ethertype;
  assign policy_ok = frame.frame_len >= off + 8'd3;
  assign ipv4_hit  = inner_type == l2c_pkg::IPV4_TYPE &&
                     frame.frame_len >= off + l2c_pkg::ETYPE_LEN + l2c_pkg::IPV4_HDR_LEN;
  assign frag_hit  = policy_ok && cfg.nonce_bytes <= l2c_pkg::NONCE_MAX &&
                     frame.frame_len >= frag_end;

  always_comb begin
    result_next = '0;
    result_next.header_kind = l2c_pkg::KIND_NONE;
    if (kind != l2c_pkg::KIND_NONE) begin
      result_next.header_kind   = kind;
      result_next.l2_prefix_len = off[4:0];
      result_next.has_marker    = is_marker;
      if (ipv4_hit) begin
        result_next.ipv4_ok     = 1'b1;
        result_next.ipv4_offset = off[4:0] + 5'd2;
      end
      if (policy_ok) begin
        result_next.policy_valid = 1'b1;
        result_next.policy_id    = pb;
      end
      if (is_marker && frame.frame_len >= off + 8'd4) begin
        result_next.worker_valid = 1'b1;
        result_next.worker_index = wb;
      end
      if (frag_hit) begin
        result_next.frag_valid        = 1'b1;
        result_next.frag_magic_offset = frag_end[5:0];
      end
    end
  end

  assign frame_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_ready) begin
      result_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ethernet_l2_header_classifier.sv @@
// Top level of the Ethernet L2 header classifier: configuration registers
// and the capture and classify stages. Depends on l2c_pkg, l2c_capture, l2c_classify.
`default_nettype none

// The classifier takes a frame one byte per transfer on the item channel and
// delivers one result transfer per frame, describing where the inner EtherType
// sits (offset 12 untagged, offset 16 behind an 802.1Q tag), whether an IPv4
// header is fully present, whether the inner type is the configured private
// marker type, and the policy, worker and fragment-magic positions behind it.
// The block takes one byte every cycle, back to back and across frame
// boundaries; the only thing that holds the item channel is a result that is
// not being taken while a second finished frame already waits behind it.
// After the transfer of a frame's last byte, its result passes through the
// capture stage's frame summary register and then the result register. Frame
// length saturates at 255 bytes. The marker EtherType (index 0) and the nonce
// length (index 1) must only be written while no frame is in flight; a marker
// value of zero turns the marker match off.

module ethernet_l2_header_classifier (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire l2c_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output l2c_pkg::result_t      result,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data
);

  l2c_pkg::cfg_t   cfg;
  l2c_pkg::frame_t frame;
  logic            frame_valid;
  logic            frame_ready;

  // Configuration registers; writes take effect at the next edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_ethertype <= l2c_pkg::MARKER_RESET;
      cfg.nonce_bytes      <= l2c_pkg::NONCE_RESET;
    end else if (cfg_write) begin
      case (l2c_pkg::reg_index_t'(cfg_index))
        l2c_pkg::REG_MARKER: cfg.marker_ethertype <= cfg_data;
        l2c_pkg::REG_NONCE:  cfg.nonce_bytes      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Counts bytes, captures the header fields and holds one finished frame.
  l2c_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Decodes the summary and registers the result.
  l2c_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/l2c_checker.sv @@
// Port-level checks for the L2 header classifier and the bind that attaches them.
// Depends on l2c_pkg and ethernet_l2_header_classifier.
`default_nettype none

module l2c_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire l2c_pkg::result_t result
);

  // A stalled result holds its value until the transfer.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The prefix length follows the header kind.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.header_kind == l2c_pkg::KIND_NONE && result.l2_prefix_len == 5'd0) ||
      (result.header_kind == l2c_pkg::KIND_UNTAGGED && result.l2_prefix_len == 5'd12) ||
      (result.header_kind == l2c_pkg::KIND_VLAN && result.l2_prefix_len == 5'd16))
    else $error("prefix length does not match header kind");

  // A frame without an accepted type reports nothing else.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.header_kind == l2c_pkg::KIND_NONE |->
      !result.ipv4_ok && !result.has_marker && !result.policy_valid &&
      !result.worker_valid && !result.frag_valid)
    else $error("flags set without an accepted type");

  // The IPv4 header starts right after the inner EtherType; a worker byte needs the marker.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (!result.ipv4_ok || result.ipv4_offset == result.l2_prefix_len + 5'd2) &&
      (!result.worker_valid || (result.has_marker && result.policy_valid)))
    else $error("inconsistent ipv4 or worker fields");

  // No result is shown right after reset.
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind ethernet_l2_header_classifier l2c_checker u_l2c_checker (.*);

`default_nettype wire
